// ===== rtl/scap_pkg.sv =====
// ----------------------------------------------------------------------------
// scap_pkg: shared types and constants of the ATR parser
// Payload structs, parser state record, phase and byte-class codes.
// ----------------------------------------------------------------------------
`default_nettype none

package scap_pkg;

  localparam int MaxLevelDefault = 15;

  // Parser phases
  localparam logic [2:0] PH_TS    = 3'd0;
  localparam logic [2:0] PH_T0    = 3'd1;
  localparam logic [2:0] PH_IFACE = 3'd2;
  localparam logic [2:0] PH_HIST  = 3'd3;
  localparam logic [2:0] PH_EXTRA = 3'd4;

  // Byte classes reported on the result channel
  localparam logic [3:0] CLS_TS    = 4'd0;
  localparam logic [3:0] CLS_T0    = 4'd1;
  localparam logic [3:0] CLS_TA    = 4'd2;
  localparam logic [3:0] CLS_TB    = 4'd3;
  localparam logic [3:0] CLS_TC    = 4'd4;
  localparam logic [3:0] CLS_TD    = 4'd5;
  localparam logic [3:0] CLS_HIST  = 4'd6;
  localparam logic [3:0] CLS_EXTRA = 4'd7;
  localparam logic [3:0] CLS_NONE  = 4'd8;

  // Interface byte slots inside one level
  localparam logic [1:0] SLOT_TA = 2'd0;
  localparam logic [1:0] SLOT_TD = 2'd3;

  // Conventions
  localparam logic [1:0] CONV_DIRECT  = 2'd0;
  localparam logic [1:0] CONV_INVERSE = 2'd1;
  localparam logic [1:0] CONV_UNKNOWN = 2'd2;

  localparam logic [7:0] TS_DIRECT  = 8'h3B;
  localparam logic [7:0] TS_INVERSE = 8'h3F;
  localparam logic [7:0] TS_NO_CARD = 8'h00;
  localparam logic [7:0] EXTRA_INIT = 8'hFF;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       line_error;
  } scap_in_t;

  typedef struct packed {
    logic [3:0]        byte_class;
    logic [3:0]        level;
    logic [7:0]        data;
    logic [1:0]        convention;
    logic [7:0]        max_clock_100khz;
    logic              clock_valid;
    logic signed [3:0] rate_shift;
    logic              rate_valid;
    logic [3:0]        protocol;
    logic              failed;
    logic              atr_done;
  } scap_out_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [3:0] pending_mask;
    logic [1:0] byte_slot;
    logic [3:0] level_count;
    logic [3:0] history_left;
    logic [7:0] previous_extra;
    logic [1:0] card_convention;
    logic [3:0] last_protocol;
  } scap_state_t;

  // Decoded TA fields
  typedef struct packed {
    logic [7:0]        max_clock;
    logic              clock_ok;
    logic signed [3:0] rate;
    logic              rate_ok;
  } scap_ta_t;

endpackage

`default_nettype wire

// ===== rtl/scap_ta_decode.sv =====
// ----------------------------------------------------------------------------
// scap_ta_decode: TA byte decoder
// Maps the TA nibbles to max clock (100 kHz units) and bit-rate shift.
// ----------------------------------------------------------------------------
`default_nettype none

module scap_ta_decode (
  input  wire logic [7:0]        ta_byte,
  output scap_pkg::scap_ta_t     ta_info
);

  always_comb begin
    ta_info.max_clock = 8'd0;
    ta_info.clock_ok  = 1'b1;
    ta_info.rate      = 4'sd0;
    ta_info.rate_ok   = 1'b1;
    case (ta_byte[7:4])
      4'd1:    ta_info.max_clock = 8'd50;
      4'd2:    ta_info.max_clock = 8'd60;
      4'd3:    ta_info.max_clock = 8'd80;
      4'd4:    ta_info.max_clock = 8'd120;
      4'd5:    ta_info.max_clock = 8'd160;
      4'd6:    ta_info.max_clock = 8'd200;
      4'd9:    ta_info.max_clock = 8'd50;
      4'd10:   ta_info.max_clock = 8'd75;
      4'd11:   ta_info.max_clock = 8'd100;
      4'd12:   ta_info.max_clock = 8'd150;
      4'd13:   ta_info.max_clock = 8'd200;
      4'd0:    ta_info.max_clock = 8'd0;   // internal clock
      default: ta_info.clock_ok  = 1'b0;   // reserved codes
    endcase
    case (ta_byte[3:0])
      4'd1:    ta_info.rate = 4'sd0;
      4'd2:    ta_info.rate = 4'sd1;
      4'd3:    ta_info.rate = 4'sd2;
      4'd4:    ta_info.rate = 4'sd3;
      4'd5:    ta_info.rate = 4'sd4;
      4'd10:   ta_info.rate = -4'sd1;
      4'd11:   ta_info.rate = -4'sd2;
      4'd12:   ta_info.rate = -4'sd3;
      4'd13:   ta_info.rate = -4'sd4;
      4'd14:   ta_info.rate = -4'sd5;
      4'd15:   ta_info.rate = -4'sd6;
      default: ta_info.rate_ok = 1'b0;     // reserved codes
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/scap_step.sv =====
// ----------------------------------------------------------------------------
// scap_step: per-byte classification and next-state logic
// One received byte plus current parser state in, result and next state out.
// ----------------------------------------------------------------------------
`default_nettype none

module scap_step #(
  parameter int MAX_LEVEL = scap_pkg::MaxLevelDefault
) (
  input  wire scap_pkg::scap_in_t    item,
  input  wire scap_pkg::scap_state_t cur,
  output scap_pkg::scap_state_t      nxt,
  output scap_pkg::scap_out_t        res
);

  scap_pkg::scap_ta_t ta_info;

  scap_ta_decode u_ta_decode (
    .ta_byte (item.rx_byte),
    .ta_info (ta_info)
  );

  // Pick the next byte to expect: lowest announced interface byte first,
  // then history, then extra bytes.
  function automatic scap_pkg::scap_state_t pick_next(input scap_pkg::scap_state_t s);
    scap_pkg::scap_state_t r;
    r = s;
    if (s.pending_mask != 4'd0) begin
      r.phase = scap_pkg::PH_IFACE;
      if (s.pending_mask[0])      r.byte_slot = 2'd0;
      else if (s.pending_mask[1]) r.byte_slot = 2'd1;
      else if (s.pending_mask[2]) r.byte_slot = 2'd2;
      else                        r.byte_slot = 2'd3;
    end else if (s.history_left != 4'd0) begin
      r.phase = scap_pkg::PH_HIST;
    end else begin
      r.phase          = scap_pkg::PH_EXTRA;
      r.previous_extra = scap_pkg::EXTRA_INIT;
    end
    return r;
  endfunction

  logic [7:0] b;
  logic       err;
  logic [3:0] cls;
  logic [3:0] lvl;
  logic       failed;
  logic       done;
  logic       ta_sel;
  scap_pkg::scap_state_t s;

  assign b   = item.rx_byte;
  assign err = item.line_error;

  always_comb begin
    s      = cur;
    cls    = scap_pkg::CLS_NONE;
    lvl    = 4'd0;
    failed = 1'b0;
    done   = 1'b0;
    ta_sel = 1'b0;
    case (cur.phase)
      scap_pkg::PH_T0: begin
        if (err) begin
          failed  = 1'b1;
          done    = 1'b1;
          s.phase = scap_pkg::PH_TS;
        end else begin
          cls             = scap_pkg::CLS_T0;
          s.pending_mask  = b[7:4];
          s.history_left  = b[3:0];
          s.level_count   = 4'd1;
          s.last_protocol = 4'd0;
          s.byte_slot     = scap_pkg::SLOT_TA;
          s               = pick_next(s);
        end
      end
      scap_pkg::PH_IFACE: begin
        if (err) begin
          failed  = 1'b1;
          done    = 1'b1;
          s.phase = scap_pkg::PH_TS;
        end else begin
          cls = scap_pkg::CLS_TA + {2'b00, cur.byte_slot};
          lvl = cur.level_count;
          s.pending_mask = cur.pending_mask & ~(4'b0001 << cur.byte_slot);
          if (cur.byte_slot == scap_pkg::SLOT_TA) begin
            ta_sel = 1'b1;
          end else if (cur.byte_slot == scap_pkg::SLOT_TD) begin
            s.last_protocol = b[3:0];
            s.pending_mask  = b[7:4];
            if ((b[7:4] != 4'd0) && (cur.level_count < 4'(MAX_LEVEL)))
              s.level_count = cur.level_count + 4'd1;
          end
          s = pick_next(s);
        end
      end
      scap_pkg::PH_HIST: begin
        if (err) begin
          failed  = 1'b1;
          done    = 1'b1;
          s.phase = scap_pkg::PH_TS;
        end else begin
          cls            = scap_pkg::CLS_HIST;
          s.history_left = cur.history_left - 4'd1;
          s              = pick_next(s);
        end
      end
      scap_pkg::PH_EXTRA: begin
        if (err || (b == cur.previous_extra)) begin
          done    = 1'b1;
          s.phase = scap_pkg::PH_TS;
        end else begin
          cls              = scap_pkg::CLS_EXTRA;
          s.previous_extra = b;
        end
      end
      default: begin
        s.phase = scap_pkg::PH_TS;
        if (err || (b == scap_pkg::TS_NO_CARD)) begin
          failed = 1'b1;
          done   = 1'b1;
        end else begin
          cls     = scap_pkg::CLS_TS;
          s.phase = scap_pkg::PH_T0;
          if (b == scap_pkg::TS_DIRECT)       s.card_convention = scap_pkg::CONV_DIRECT;
          else if (b == scap_pkg::TS_INVERSE) s.card_convention = scap_pkg::CONV_INVERSE;
          else                                s.card_convention = scap_pkg::CONV_UNKNOWN;
        end
      end
    endcase
  end

  assign nxt = s;

  always_comb begin
    res.byte_class       = cls;
    res.level            = lvl;
    res.data             = err ? 8'd0 : b;
    res.convention       = s.card_convention;
    res.max_clock_100khz = ta_sel ? ta_info.max_clock : 8'd0;
    res.clock_valid      = ta_sel & ta_info.clock_ok;
    res.rate_shift       = ta_sel ? ta_info.rate : 4'sd0;
    res.rate_valid       = ta_sel & ta_info.rate_ok;
    res.protocol         = s.last_protocol;
    res.failed           = failed;
    res.atr_done         = done;
  end

endmodule

`default_nettype wire

// ===== rtl/scap_out_buf.sv =====
// ----------------------------------------------------------------------------
// scap_out_buf: result register with skid stage
// Holds results while the consumer stalls; ready drops only when both full.
// ----------------------------------------------------------------------------
`default_nettype none

module scap_out_buf (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire scap_pkg::scap_out_t push_data,
  output logic                     can_push,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output scap_pkg::scap_out_t      out_data
);

  logic                main_v_r, main_v_nxt;
  logic                skid_v_r, skid_v_nxt;
  scap_pkg::scap_out_t main_r, main_nxt;
  scap_pkg::scap_out_t skid_r, skid_nxt;

  assign can_push  = ~skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (!main_v_r || out_ready) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        main_v_nxt = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        main_nxt   = push_data;
        main_v_nxt = push;
      end
    end else if (push) begin
      skid_nxt   = push_data;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

`ifndef SYNTHESIS
  a_skid_implies_main : assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry held with empty result register");
`endif

endmodule

`default_nettype wire

// ===== rtl/smart_card_atr_parser_unit.sv =====
// ----------------------------------------------------------------------------
// smart_card_atr_parser_unit: ISO 7816-3 answer-to-reset byte classifier
// Top level: parser state register, per-byte step logic, result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

// Feed the received ATR bytes one per transfer on the in_ channel (or a
// transfer with line_error set when a read fails or times out); each input
// transfer yields exactly one result transfer on the out_ channel, in order.
// The result tells what the byte was (TS, T0, TA..TD with their level,
// historical, extra, or none/error), the convention taken from TS, the
// decoded TA fields, the latest TD protocol and failure/done flags. An input
// byte is taken every cycle while in_ready is high: the whole classification
// and state update is a single short step between the parser state register
// and the result register (or the skid entry while that register stalls).
// A two-deep result buffer (result register plus skid entry) keeps in_ready
// high while one result waits; in_ready drops only when two results are
// pending. When atr_done is set on a result, the parser is already back to
// waiting for TS. MAX_LEVEL (2..15) caps the reported interface level.
module smart_card_atr_parser_unit #(
  parameter int MAX_LEVEL = scap_pkg::MaxLevelDefault
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire scap_pkg::scap_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output scap_pkg::scap_out_t      out_data
);

  scap_pkg::scap_state_t state_r;
  scap_pkg::scap_state_t state_nxt;
  scap_pkg::scap_state_t step_state;
  scap_pkg::scap_out_t   step_res;
  logic                  in_xfer;

  // Combinational step for the byte on the input port
  scap_step #(
    .MAX_LEVEL (MAX_LEVEL)
  ) u_step (
    .item (in_data),
    .cur  (state_r),
    .nxt  (step_state),
    .res  (step_res)
  );

  assign in_xfer   = in_valid & in_ready;
  assign state_nxt = in_xfer ? step_state : state_r;

  // Parser state: updated only on an input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase           <= scap_pkg::PH_TS;
      state_r.pending_mask    <= 4'd0;
      state_r.byte_slot       <= 2'd0;
      state_r.level_count     <= 4'd1;
      state_r.history_left    <= 4'd0;
      state_r.previous_extra  <= scap_pkg::EXTRA_INIT;
      state_r.card_convention <= scap_pkg::CONV_DIRECT;
      state_r.last_protocol   <= 4'd0;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Result register and skid entry
  scap_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_data (step_res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_done_to_ts : assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && step_res.atr_done) |=> (state_r.phase == scap_pkg::PH_TS))
    else $error("parser not back at TS after end of ATR");

  a_failed_done : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.failed) |-> out_data.atr_done)
    else $error("failure reported without end of ATR");

  a_level_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.level_count != 4'd0) && (state_r.level_count <= 4'(MAX_LEVEL)))
    else $error("level count out of range");

  a_iface_level : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_data.byte_class == scap_pkg::CLS_TA) ||
                   (out_data.byte_class == scap_pkg::CLS_TB) ||
                   (out_data.byte_class == scap_pkg::CLS_TC) ||
                   (out_data.byte_class == scap_pkg::CLS_TD)))
      |-> (out_data.level != 4'd0))
    else $error("interface byte reported without level");

  a_iface_mask : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == scap_pkg::PH_IFACE) |-> (state_r.pending_mask != 4'd0))
    else $error("expecting interface byte with nothing announced");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: answer-to-reset parser testbench
// Feeds ATR byte streams (a short directed table, then mostly well-formed
// random ATRs with some noise and line errors) through the valid/ready input
// and checks each result transfer against a typed row or in-bench classifier.
// Traffic runs under several gap/stall mixes plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int LEVEL_CAP       = scap_pkg::MaxLevelDefault;
  localparam int RANDOM_ITEMS    = 400;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int DIRECTED_ROWS   = 25;

  // One row of the directed table. When typed is set, want is the result
  // read straight off the spec; otherwise the classifier supplies it.
  typedef struct packed {
    scap_pkg::scap_in_t  stim;
    logic                typed;
    scap_pkg::scap_out_t want;
  } atr_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  scap_pkg::scap_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  scap_pkg::scap_out_t out_data;

  smart_card_atr_parser_unit #(.MAX_LEVEL(LEVEL_CAP)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Classifier state: mirrors the parser as of the last accepted byte.
  logic [2:0] atr_phase;
  logic [3:0] iface_mask;   // interface bytes still announced at this level
  logic [1:0] iface_slot;   // which of TA..TD comes next
  logic [3:0] iface_level;
  logic [3:0] hist_count;
  logic [7:0] last_extra;
  logic [1:0] card_conv;
  logic [3:0] td_protocol;

  // Stimulus shaping
  logic       deep_chain;   // this ATR keeps announcing levels past the cap
  int         td_seen;
  int         atr_starts;

  scap_pkg::scap_out_t expected_results[$];
  scap_pkg::scap_out_t oldest_expected;
  atr_row_t            atr_rows[DIRECTED_ROWS];

  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int cycle_count   = 0;
  int transfers_checked = 0;
  int mismatch_count    = 0;
  int atr_endings       = 0;
  int atr_failures      = 0;
  int deepest_level     = 0;

  int idle_by_phase[4]  = '{0, 45, 0, 28};
  int stall_by_phase[4] = '{0, 0, 45, 28};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // After a byte is consumed: next announced interface byte (lowest slot
  // first), else historical bytes, else extras with the repeat detector armed.
  function automatic void next_field();
    if (iface_mask != 4'h0) begin
      atr_phase = scap_pkg::PH_IFACE;
      for (int i = 3; i >= 0; i--) begin
        if (iface_mask[i]) iface_slot = 2'(i);
      end
    end else if (hist_count != 4'h0) begin
      atr_phase = scap_pkg::PH_HIST;
    end else begin
      atr_phase = scap_pkg::PH_EXTRA;
      last_extra = scap_pkg::EXTRA_INIT;
    end
  endfunction

  // Expected result of one accepted byte; advances the classifier state.
  function automatic scap_pkg::scap_out_t classify_atr_byte(scap_pkg::scap_in_t item);
    scap_pkg::scap_out_t r;
    logic [7:0] b;
    logic [3:0] fi;
    logic [3:0] di;
    b  = item.rx_byte;
    fi = b[7:4];
    di = b[3:0];
    r  = '0;
    r.byte_class = scap_pkg::CLS_NONE;
    r.data = item.line_error ? 8'h00 : b;
    case (atr_phase)
      scap_pkg::PH_T0: begin
        if (item.line_error) begin
          r.failed = 1'b1;
          r.atr_done = 1'b1;
          atr_phase = scap_pkg::PH_TS;
        end else begin
          r.byte_class = scap_pkg::CLS_T0;
          iface_mask  = fi;
          hist_count  = di;
          iface_level = 4'd1;
          td_protocol = 4'h0;
          iface_slot  = scap_pkg::SLOT_TA;
          next_field();
        end
      end
      scap_pkg::PH_IFACE: begin
        if (item.line_error) begin
          r.failed = 1'b1;
          r.atr_done = 1'b1;
          atr_phase = scap_pkg::PH_TS;
        end else begin
          r.byte_class = scap_pkg::CLS_TA + 4'(iface_slot);
          r.level = iface_level;
          iface_mask[iface_slot] = 1'b0;
          if (iface_slot == scap_pkg::SLOT_TA) begin
            // high nibble: clock rate conversion, low nibble: bit-rate adjust
            case (fi)
              4'd1, 4'd9:  r.max_clock_100khz = 8'd50;
              4'd2:        r.max_clock_100khz = 8'd60;
              4'd3:        r.max_clock_100khz = 8'd80;
              4'd4:        r.max_clock_100khz = 8'd120;
              4'd5:        r.max_clock_100khz = 8'd160;
              4'd6, 4'd13: r.max_clock_100khz = 8'd200;
              4'd10:       r.max_clock_100khz = 8'd75;
              4'd11:       r.max_clock_100khz = 8'd100;
              4'd12:       r.max_clock_100khz = 8'd150;
              default:     r.max_clock_100khz = 8'd0;
            endcase
            r.clock_valid = !(fi inside {4'd7, 4'd8, 4'd14, 4'd15});
            r.rate_valid  = di inside {[4'd1:4'd5], [4'd10:4'd15]};
            if (di >= 4'd1 && di <= 4'd5) r.rate_shift = di - 4'd1;
            else if (di >= 4'd10) r.rate_shift = 4'd9 - di;
          end else if (iface_slot == scap_pkg::SLOT_TD) begin
            td_protocol = di;
            iface_mask  = fi;
            if (fi != 4'h0 && iface_level < LEVEL_CAP) iface_level = iface_level + 4'd1;
          end
          next_field();
        end
      end
      scap_pkg::PH_HIST: begin
        if (item.line_error) begin
          r.failed = 1'b1;
          r.atr_done = 1'b1;
          atr_phase = scap_pkg::PH_TS;
        end else begin
          r.byte_class = scap_pkg::CLS_HIST;
          hist_count = hist_count - 4'd1;
          next_field();
        end
      end
      scap_pkg::PH_EXTRA: begin
        // extras end quietly: line error or a byte equal to the one before
        if (item.line_error || b == last_extra) begin
          r.atr_done = 1'b1;
          atr_phase = scap_pkg::PH_TS;
        end else begin
          r.byte_class = scap_pkg::CLS_EXTRA;
          last_extra = b;
        end
      end
      default: begin
        atr_phase = scap_pkg::PH_TS;
        if (item.line_error || b == scap_pkg::TS_NO_CARD) begin
          r.failed = 1'b1;
          r.atr_done = 1'b1;
        end else begin
          r.byte_class = scap_pkg::CLS_TS;
          card_conv = (b == scap_pkg::TS_DIRECT)  ? scap_pkg::CONV_DIRECT :
                      (b == scap_pkg::TS_INVERSE) ? scap_pkg::CONV_INVERSE :
                                                    scap_pkg::CONV_UNKNOWN;
          atr_phase = scap_pkg::PH_T0;
        end
      end
    endcase
    r.convention = card_conv;
    r.protocol = td_protocol;
    return r;
  endfunction

  // Next random byte, shaped by where the parser stands so most ATRs get
  // past T0 and into levels, history and extras.
  function automatic scap_pkg::scap_in_t pick_atr_byte();
    scap_pkg::scap_in_t it;
    logic               keep_clean;
    it = '0;
    it.rx_byte = 8'($urandom);
    keep_clean = deep_chain && atr_phase == scap_pkg::PH_IFACE;
    if (!keep_clean && $urandom_range(0, 99) < 3) begin
      it.line_error = 1'b1;
      return it;
    end
    if (!keep_clean && $urandom_range(0, 99) < 4) return it;  // plain noise
    case (atr_phase)
      scap_pkg::PH_TS: begin
        deep_chain = (atr_starts % 8 == 1);
        atr_starts++;
        case ($urandom_range(0, 19))
          0:       it.rx_byte = scap_pkg::TS_NO_CARD;
          1, 2, 3, 4, 5, 6, 7, 8, 9: it.rx_byte = scap_pkg::TS_DIRECT;
          10, 11, 12, 13, 14, 15, 16: it.rx_byte = scap_pkg::TS_INVERSE;
          default: ;
        endcase
      end
      scap_pkg::PH_T0: begin
        td_seen = 0;
        if ($urandom_range(0, 3) != 0) it.rx_byte[3:0] = 4'($urandom_range(0, 3));
      end
      scap_pkg::PH_IFACE: begin
        if (iface_slot == scap_pkg::SLOT_TD) begin
          td_seen++;
          if (deep_chain) begin
            if (td_seen < LEVEL_CAP + 3) it.rx_byte[7] = 1'b1;
            else it.rx_byte[7:4] = 4'h0;
          end else if ($urandom_range(0, 99) < 60) begin
            it.rx_byte[7:4] = 4'h0;
          end
        end
      end
      scap_pkg::PH_EXTRA: begin
        if ($urandom_range(0, 3) == 0) it.rx_byte = last_extra;
      end
      default: ;
    endcase
    return it;
  endfunction

  function automatic scap_pkg::scap_out_t plain_result(logic [3:0] cls, logic [7:0] data,
                                                       logic [1:0] conv, logic [3:0] proto,
                                                       logic failed, logic done);
    scap_pkg::scap_out_t r;
    r = '0;
    r.byte_class = cls;
    r.data       = data;
    r.convention = conv;
    r.protocol   = proto;
    r.failed     = failed;
    r.atr_done   = done;
    return r;
  endfunction

  function automatic string fmt_result(scap_pkg::scap_out_t r);
    return $sformatf({"cls %0d lvl %0d data %h conv %0d clk %0d/%b rate %0d/%b",
                      " proto %0d fail %b done %b"},
                     r.byte_class, r.level, r.data, r.convention, r.max_clock_100khz,
                     r.clock_valid, r.rate_shift, r.rate_valid, r.protocol, r.failed,
                     r.atr_done);
  endfunction

  // Offer one byte (after a random gap), hold it until the transfer, then
  // record what should come back.
  task automatic send_item(input scap_pkg::scap_in_t item, input logic typed,
                           input scap_pkg::scap_out_t want);
    scap_pkg::scap_out_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    predicted = classify_atr_byte(item);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // Drop valid and pause until every outstanding result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Result side: random stalls, plus a long hold-off on request that lets
  // the two-deep result buffer fill and back-pressure the input.
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Cycle limit and result checking.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("FAILURE");
      $finish;
    end else if (rst_n && out_valid && out_ready) begin
      transfers_checked++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with nothing pending: %s", $realtime, fmt_result(out_data));
      end else begin
        oldest_expected = expected_results.pop_front();
        if (out_data.byte_class !== oldest_expected.byte_class ||
            out_data.level !== oldest_expected.level ||
            out_data.data !== oldest_expected.data ||
            out_data.convention !== oldest_expected.convention ||
            out_data.max_clock_100khz !== oldest_expected.max_clock_100khz ||
            out_data.clock_valid !== oldest_expected.clock_valid ||
            out_data.rate_shift !== oldest_expected.rate_shift ||
            out_data.rate_valid !== oldest_expected.rate_valid ||
            out_data.protocol !== oldest_expected.protocol ||
            out_data.failed !== oldest_expected.failed ||
            out_data.atr_done !== oldest_expected.atr_done) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: mismatch on transfer %0d", $realtime, transfers_checked);
            $display("  expected %s", fmt_result(oldest_expected));
            $display("  actual   %s", fmt_result(out_data));
          end
        end
      end
      if (out_data.atr_done) atr_endings++;
      if (out_data.failed) atr_failures++;
      if (int'(out_data.level) > deepest_level) deepest_level = out_data.level;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;

    atr_phase   = scap_pkg::PH_TS;
    iface_mask  = 4'h0;
    iface_slot  = scap_pkg::SLOT_TA;
    iface_level = 4'd1;
    hist_count  = 4'h0;
    last_extra  = scap_pkg::EXTRA_INIT;
    card_conv   = scap_pkg::CONV_DIRECT;
    td_protocol = 4'h0;
    deep_chain  = 1'b0;
    td_seen     = 0;
    atr_starts  = 0;

    // Directed walk: no card, line error on TS, inverse TS with nothing
    // announced and an immediate repeat, a two-level ATR (TA extremes, TD
    // protocol, history, extras ended by line error), unknown convention
    // cut in T0, and a line error where TA is due.
    atr_rows = '{
      '{'{8'h00, 1'b0}, 1'b1,
        plain_result(scap_pkg::CLS_NONE, 8'h00, scap_pkg::CONV_DIRECT, 4'h0, 1'b1, 1'b1)},
      '{'{8'hAB, 1'b1}, 1'b1,
        plain_result(scap_pkg::CLS_NONE, 8'h00, scap_pkg::CONV_DIRECT, 4'h0, 1'b1, 1'b1)},
      '{'{scap_pkg::TS_INVERSE, 1'b0}, 1'b1,
        plain_result(scap_pkg::CLS_TS, scap_pkg::TS_INVERSE, scap_pkg::CONV_INVERSE, 4'h0,
                     1'b0, 1'b0)},
      '{'{8'h00, 1'b0}, 1'b1,
        plain_result(scap_pkg::CLS_T0, 8'h00, scap_pkg::CONV_INVERSE, 4'h0, 1'b0, 1'b0)},
      '{'{8'hFF, 1'b0}, 1'b1,
        plain_result(scap_pkg::CLS_NONE, 8'hFF, scap_pkg::CONV_INVERSE, 4'h0, 1'b0, 1'b1)},
      '{'{scap_pkg::TS_DIRECT, 1'b0}, 1'b1,
        plain_result(scap_pkg::CLS_TS, scap_pkg::TS_DIRECT, scap_pkg::CONV_DIRECT, 4'h0,
                     1'b0, 1'b0)},
      '{'{8'hF2, 1'b0}, 1'b0, '0},
      '{'{8'h11, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0}, 1'b0, '0},
      '{'{8'hF1, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0}, 1'b0, '0},
      '{'{8'h0E, 1'b0}, 1'b0, '0},
      '{'{8'h80, 1'b0}, 1'b0, '0},
      '{'{8'h7F, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0}, 1'b0, '0},
      '{'{8'h55, 1'b0}, 1'b0, '0},
      '{'{8'hC3, 1'b1}, 1'b1,
        plain_result(scap_pkg::CLS_NONE, 8'h00, scap_pkg::CONV_DIRECT, 4'hE, 1'b0, 1'b1)},
      '{'{8'h12, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b1}, 1'b1,
        plain_result(scap_pkg::CLS_NONE, 8'h00, scap_pkg::CONV_UNKNOWN, 4'hE, 1'b1, 1'b1)},
      '{'{scap_pkg::TS_DIRECT, 1'b0}, 1'b0, '0},
      '{'{8'h10, 1'b0}, 1'b0, '0},
      '{'{8'h5A, 1'b1}, 1'b1,
        plain_result(scap_pkg::CLS_NONE, 8'h00, scap_pkg::CONV_DIRECT, 4'h0, 1'b1, 1'b1)}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (atr_rows[i]) send_item(atr_rows[i].stim, atr_rows[i].typed, atr_rows[i].want);
    drain_results();

    // Random ATRs in four traffic mixes; the first one also gets the long
    // receiver hold-off while the input keeps offering bytes.
    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_by_phase[p];
      stall_pct <= stall_by_phase[p];
      if (p == 0) hold_requests <= hold_requests + 1;
      repeat (RANDOM_ITEMS / 4) send_item(pick_atr_byte(), 1'b0, '0);
      drain_results();
    end

    repeat (8) @(posedge clk);

    $display("checked %0d result transfers; %0d ATRs ended, %0d of them failed",
             transfers_checked, atr_endings, atr_failures);
    $display("deepest interface level reported %0d, mismatches %0d",
             deepest_level, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
